>>> src/pfa_pkg.sv
// pfa_pkg: shared types and constants of the partition fit allocator.
// Holds the word structs, status, action and mode codes, and table sizing.
// Depends on nothing.
`timescale 1ns / 1ps

package pfa_pkg;

  localparam int NUM_PARTS = 32;
  localparam int SIZE_BITS = 16;
  localparam int IDX_W     = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
  localparam int CNT_W     = $clog2(NUM_PARTS + 1);

  localparam int FIT_W   = 2;
  localparam int PARTS_W = 6;
  localparam int CFG_W   = 6;
  localparam int CFGI_W  = 1;

  localparam logic [CFGI_W-1:0] REG_FIT_MODE = 1'd0;
  localparam logic [CFGI_W-1:0] REG_PARTS    = 1'd1;

  localparam logic [FIT_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [FIT_W-1:0] MODE_BEST  = 2'd1;
  localparam logic [FIT_W-1:0] MODE_WORST = 2'd2;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

  localparam logic [1:0] ST_LOADED  = 2'd0;
  localparam logic [1:0] ST_GRANTED = 2'd1;
  localparam logic [1:0] ST_WAIT    = 2'd2;

  localparam logic [PARTS_W-1:0] PARTS_RESET = 6'd32;

  typedef struct packed {
    logic        action;
    logic [4:0]  part_slot;
    logic [15:0] amount;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  chosen_slot;
    logic [15:0] left_after;
  } out_word_t;

endpackage

>>> src/partition_fit_allocator.sv
// partition_fit_allocator: first, best and worst fit over a partition table.
// The free-size table is a one-port-read, one-port-write memory in this module.
// Depends on pfa_pkg.
`timescale 1ns / 1ps

//  channel | ports                          | moves
//  --------+--------------------------------+-------------------------------
//  input   | in_valid in_ready in_data      | pfa_pkg::in_word_t word
//  result  | out_valid out_ready out_data   | pfa_pkg::out_word_t word
//  config  | cfg_we cfg_index cfg_wdata     | register write, no handshake
//
// A load goes through the result register, then in S_DONE to the output register;
// a request scans in S_SCAN, writes the table in S_WRITE and ends in S_DONE, the
// scan reading one table entry a cycle over the searched partitions.
// One item is in work at a time; in_ready is high only between items.
// Reset clears the table through per-entry valid bits.
// A result waiting in the output register stalls only the finish of the next item.

module partition_fit_allocator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  pfa_pkg::in_word_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output pfa_pkg::out_word_t                   out_data,
  input  logic                                 cfg_we,
  input  logic [pfa_pkg::CFGI_W-1:0]           cfg_index,
  input  logic [pfa_pkg::CFG_W-1:0]            cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_WRITE = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                           state_r, state_nxt;
  logic [pfa_pkg::FIT_W-1:0]        fit_mode_r;
  logic [pfa_pkg::PARTS_W-1:0]      parts_r;

  logic [pfa_pkg::SIZE_BITS-1:0]    mem [pfa_pkg::NUM_PARTS];
  logic [pfa_pkg::NUM_PARTS-1:0]    valid_r;
  logic [pfa_pkg::SIZE_BITS-1:0]    mem_q_r;
  logic                             vb_q_r;

  logic                             rd_en;
  logic [pfa_pkg::IDX_W-1:0]        raddr;
  logic                             wr_en;
  logic [pfa_pkg::IDX_W-1:0]        waddr;
  logic [pfa_pkg::SIZE_BITS-1:0]    wdata;

  logic [pfa_pkg::SIZE_BITS-1:0]    req_amt_r, req_amt_nxt;
  logic [pfa_pkg::CNT_W-1:0]        scan_n_r, scan_n_nxt;
  logic [pfa_pkg::CNT_W-1:0]        raddr_r, raddr_nxt;
  logic                             rd_vld_r, rd_vld_nxt;
  logic [pfa_pkg::IDX_W-1:0]        rd_idx_r, rd_idx_nxt;
  logic                             found_r, found_nxt;
  logic [pfa_pkg::IDX_W-1:0]        pick_r, pick_nxt;
  logic [pfa_pkg::SIZE_BITS-1:0]    pick_v_r, pick_v_nxt;
  pfa_pkg::out_word_t               res_r, res_nxt;
  logic                             out_valid_r, out_valid_nxt;
  pfa_pkg::out_word_t               out_data_r, out_data_nxt;

  logic                             in_acc;
  logic [pfa_pkg::SIZE_BITS-1:0]    in_amt;
  logic                             slot_ok;
  logic [pfa_pkg::SIZE_BITS-1:0]    cur_v;
  logic                             fits;
  logic                             take;
  logic [pfa_pkg::SIZE_BITS-1:0]    left_v;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign in_amt    = in_data.amount[pfa_pkg::SIZE_BITS-1:0];
  assign slot_ok   = (32'(in_data.part_slot) < pfa_pkg::NUM_PARTS);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // entries never written read as zero
  assign cur_v  = vb_q_r ? mem_q_r : '0;
  assign fits   = (cur_v >= req_amt_r);
  assign take   = rd_vld_r && fits &&
                  (!found_r ||
                   ((fit_mode_r == pfa_pkg::MODE_BEST)  && (cur_v < pick_v_r)) ||
                   ((fit_mode_r == pfa_pkg::MODE_WORST) && (cur_v > pick_v_r)));
  assign left_v = pick_v_r - req_amt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r <= pfa_pkg::MODE_FIRST;
      parts_r    <= pfa_pkg::PARTS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pfa_pkg::REG_FIT_MODE: fit_mode_r <= cfg_wdata[pfa_pkg::FIT_W-1:0];
        pfa_pkg::REG_PARTS:    parts_r    <= cfg_wdata[pfa_pkg::PARTS_W-1:0];
        default: ;
      endcase
    end
  end

  // table memory: registered read, single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      mem_q_r <= mem[raddr];
      vb_q_r  <= valid_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    req_amt_nxt   = req_amt_r;
    scan_n_nxt    = scan_n_r;
    raddr_nxt     = raddr_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    found_nxt     = found_r;
    pick_nxt      = pick_r;
    pick_v_nxt    = pick_v_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    raddr         = raddr_r[pfa_pkg::IDX_W-1:0];
    wr_en         = 1'b0;
    waddr         = in_data.part_slot[pfa_pkg::IDX_W-1:0];
    wdata         = in_amt;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.action == pfa_pkg::ACT_LOAD) begin
            wr_en                = slot_ok;
            res_nxt.status       = pfa_pkg::ST_LOADED;
            res_nxt.chosen_slot  = in_data.part_slot;
            res_nxt.left_after   = slot_ok ? 16'(in_amt) : '0;
            state_nxt            = S_DONE;
          end else begin
            req_amt_nxt = in_amt;
            scan_n_nxt  = (32'(parts_r) > pfa_pkg::NUM_PARTS) ?
                          pfa_pkg::CNT_W'(pfa_pkg::NUM_PARTS) :
                          pfa_pkg::CNT_W'(parts_r);
            raddr_nxt   = '0;
            found_nxt   = 1'b0;
            pick_nxt    = '0;
            pick_v_nxt  = '0;
            state_nxt   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // issue one read a cycle, judge the entry read the cycle before
        if (raddr_r < scan_n_r) begin
          rd_en      = 1'b1;
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = raddr_r[pfa_pkg::IDX_W-1:0];
          raddr_nxt  = raddr_r + 1'b1;
        end else if (!rd_vld_r) begin
          state_nxt = S_WRITE;
        end
        if (take) begin
          found_nxt  = 1'b1;
          pick_nxt   = rd_idx_r;
          pick_v_nxt = cur_v;
        end
      end
      S_WRITE: begin
        if (found_r) begin
          wr_en               = 1'b1;
          waddr               = pick_r;
          wdata               = left_v;
          res_nxt.status      = pfa_pkg::ST_GRANTED;
          res_nxt.chosen_slot = 5'(pick_r);
          res_nxt.left_after  = 16'(left_v);
        end else begin
          res_nxt.status      = pfa_pkg::ST_WAIT;
          res_nxt.chosen_slot = '0;
          res_nxt.left_after  = '0;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the output register frees
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      raddr_r     <= '0;
      scan_n_r    <= '0;
      pick_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      raddr_r     <= raddr_nxt;
      scan_n_r    <= scan_n_nxt;
      pick_r      <= pick_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_amt_r  <= req_amt_nxt;
    rd_idx_r   <= rd_idx_nxt;
    pick_v_r   <= pick_v_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef ASSERT_OFF
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !wr_en)
    else $error("table written during scan");

  a_read_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == S_SCAN))
    else $error("read data pending outside scan");

  a_pick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> (32'(pick_r) < 32'(scan_n_r)))
    else $error("picked partition beyond searched range");
`endif

endmodule
